// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the nth root block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication check failed");

// next-cycle implication, checked on every rising clock edge outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication check failed");

`endif

// ----- src/inr_pkg.sv -----
// ----------------------------------------------------------------------------
// inr_pkg
// shared widths and controller/datapath interface types of the nth root block
// ----------------------------------------------------------------------------
package inr_pkg;

   // fixed payload widths
   localparam int INR_VALUE_W  = 64;
   localparam int INR_DEGREE_W = 6;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;         // capture request, clear root, set top trial bit
      logic trial_init;   // start a trial: acc = 1, multiply count = degree
      logic mul_en;       // run the shared multiplier this cycle
      logic mul_hi_sel;   // multiply upper accumulator half instead of lower
      logic acc_update;   // take the checked product as new accumulator
      logic keep_bit;     // candidate passed, keep it as the root
      logic bit_step;     // move to the next lower root bit
      logic result_load;  // move the finished root into the output register
   } inr_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic deg_le_one;   // degree zero or one, root is the value itself
      logic acc_hi_zero;  // upper accumulator half is zero
      logic check_fail;   // product exceeds the value
      logic cnt_last;     // last multiply of the current trial
      logic bit_last;     // current trial bit is bit zero
      logic out_free;     // output register can take a result this cycle
   } inr_status_type;

endpackage

// ----- src/integer_nth_root_top.sv -----
// ----------------------------------------------------------------------------
// integer_nth_root_top
// floor of the degree-th root of an unsigned value, by bitwise trial
// ----------------------------------------------------------------------------
// Usage: a request carries req_value and req_degree on req_valid/req_ready;
// the response carries rsp_root on rsp_valid/rsp_ready. rsp_root is the
// largest r with r**degree <= value, over the low VALUE_BITS value bits.
// Degree zero or one returns the value, a value of zero returns zero.
// One request is worked on at a time. Degree zero or one: the request goes
// through the trial and finish states straight to the output register.
// Otherwise each of the ceil(VALUE_BITS/2) root bits takes a setup state
// plus, per multiply tried, a low pass and a check (and a high pass while
// the accumulator is above half width); a trial stops at its first multiply
// that exceeds the value and runs at most degree multiplies. All multiplies
// go through one half-width multiplier.
// A finished root waits in an output register, so the next request is taken
// while the previous response is still pending; a stalled receiver holds the
// response and, once the next root is done, the controller waits for it.
// Reset clears the controller and the response valid; no clearing pass.
// ----------------------------------------------------------------------------
module integer_nth_root_top #(
   parameter int VALUE_BITS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [inr_pkg::INR_VALUE_W-1:0]  req_value,
   input  logic [inr_pkg::INR_DEGREE_W-1:0] req_degree,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [inr_pkg::INR_VALUE_W-1:0]  rsp_root
);
   import inr_pkg::*;

   inr_cmd_type    cmd;
   inr_status_type status;

   // sequencer
   inr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // operands, multiplier and output register
   inr_dpath #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_value  (req_value),
      .req_degree (req_degree),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_root   (rsp_root),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

// ----- src/inr_ctrl.sv -----
// ----------------------------------------------------------------------------
// inr_ctrl
// sequencer for the bitwise root trial: request intake, multiply passes,
// power check and result hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module inr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  inr_pkg::inr_status_type status,
   output inr_pkg::inr_cmd_type    cmd
);
   import inr_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TRIAL,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (status.deg_le_one) begin
               state_in = ST_FINISH;
            end else begin
               cmd.trial_init = 1'b1;
               state_in       = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_en = 1'b1;
            state_in   = status.acc_hi_zero ? ST_CHECK : ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_en     = 1'b1;
            cmd.mul_hi_sel = 1'b1;
            state_in       = ST_CHECK;
         end
         ST_CHECK: begin
            if (!status.check_fail && !status.cnt_last) begin
               // power still fits, keep multiplying
               cmd.acc_update = 1'b1;
               state_in       = ST_MUL_LO;
            end else begin
               // trial decided: keep the bit on a full pass
               cmd.keep_bit = !status.check_fail;
               if (status.bit_last) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.bit_step = 1'b1;
                  state_in     = ST_TRIAL;
               end
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // controller checks
   `ASSERT_IMPLIES(a_load_only_when_free, clock, reset, cmd.result_load, status.out_free)
   `ASSERT_IMPLIES(a_no_step_past_bit0, clock, reset, cmd.bit_step, !status.bit_last)
   `ASSERT_IMPLIES(a_keep_only_on_fit, clock, reset, cmd.keep_bit, !status.check_fail)

endmodule

// ----- src/inr_dpath.sv -----
// ----------------------------------------------------------------------------
// inr_dpath
// datapath of the nth root block: operand registers, shared half-width
// multiplier, power accumulator with bound check, and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module inr_dpath #(
   parameter int VALUE_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [inr_pkg::INR_VALUE_W-1:0]     req_value,
   input  logic [inr_pkg::INR_DEGREE_W-1:0]    req_degree,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [inr_pkg::INR_VALUE_W-1:0]     rsp_root,
   input  inr_pkg::inr_cmd_type                cmd,
   output inr_pkg::inr_status_type             status
);
   import inr_pkg::*;

   // root of degree two or more fits in half the value bits, rounded up
   localparam int HALF_W    = (VALUE_BITS + 1) / 2;
   localparam int PROD_W    = 2 * HALF_W;
   localparam int SUM_W     = 3 * HALF_W + 1;
   localparam int BIT_W     = $clog2(HALF_W);
   localparam int HI_W      = VALUE_BITS - HALF_W;

   logic [VALUE_BITS-1:0]   value_ff;
   logic [INR_DEGREE_W-1:0] degree_ff;
   logic [HALF_W-1:0]       root_ff;
   logic [BIT_W-1:0]        bit_ff;
   logic [VALUE_BITS-1:0]   acc_ff;
   logic [INR_DEGREE_W-1:0] cnt_ff;
   logic [PROD_W-1:0]       plo_ff;
   logic [PROD_W-1:0]       phi_ff;
   logic                    rsp_valid_ff;
   logic [VALUE_BITS-1:0]   rsp_root_ff;

   logic [HALF_W-1:0]       cand;
   logic [HALF_W-1:0]       acc_lo;
   logic [HALF_W-1:0]       acc_hi;
   logic [HALF_W-1:0]       mul_a;
   logic [PROD_W-1:0]       prod;
   logic [SUM_W-1:0]        sum;
   logic [VALUE_BITS-1:0]   root_sel;

   // candidate: current root with the trial bit set
   assign cand = root_ff | (HALF_W'(1) << bit_ff);

   // shared multiplier, one accumulator half per pass
   assign acc_lo = acc_ff[HALF_W-1:0];
   assign acc_hi = HALF_W'(acc_ff[VALUE_BITS-1:HALF_W]);
   assign mul_a  = cmd.mul_hi_sel ? acc_hi : acc_lo;
   assign prod   = mul_a * cand;

   // full product from the two registered halves
   assign sum = SUM_W'({phi_ff, {HALF_W{1'b0}}}) + SUM_W'(plo_ff);

   // finished root, value itself for degree zero or one
   assign root_sel = status.deg_le_one ? value_ff : VALUE_BITS'(root_ff);

   // status toward the controller
   assign status.deg_le_one  = (degree_ff <= INR_DEGREE_W'(1));
   assign status.acc_hi_zero = (acc_ff[VALUE_BITS-1:HALF_W] == HI_W'(0));
   assign status.check_fail  = (sum > SUM_W'(value_ff));
   assign status.cnt_last    = (cnt_ff == INR_DEGREE_W'(1));
   assign status.bit_last    = (bit_ff == BIT_W'(0));
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   // request operands and root bit walk
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_ff  <= req_value[VALUE_BITS-1:0];
         degree_ff <= req_degree;
         root_ff   <= '0;
         bit_ff    <= BIT_W'(HALF_W - 1);
      end else begin
         if (cmd.keep_bit) begin
            root_ff <= cand;
         end
         if (cmd.bit_step) begin
            bit_ff <= bit_ff - BIT_W'(1);
         end
      end
   end

   // power accumulator and multiply count
   always_ff @(posedge clock) begin
      if (cmd.trial_init) begin
         acc_ff <= VALUE_BITS'(1);
         cnt_ff <= degree_ff;
      end else if (cmd.acc_update) begin
         acc_ff <= sum[VALUE_BITS-1:0];
         cnt_ff <= cnt_ff - INR_DEGREE_W'(1);
      end
   end

   // product registers, upper half cleared on the low pass
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         if (cmd.mul_hi_sel) begin
            phi_ff <= prod;
         end else begin
            plo_ff <= prod;
            phi_ff <= '0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_root_ff <= root_sel;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_root  = INR_VALUE_W'(rsp_root_ff);

   // datapath checks
   `ASSERT_NEXT(a_acc_within_value, clock, reset, cmd.acc_update, acc_ff <= value_ff)
   `ASSERT_IMPLIES(a_hi_pass_needed, clock, reset, cmd.mul_en && cmd.mul_hi_sel, !status.acc_hi_zero)
   `ASSERT_IMPLIES(a_count_nonzero, clock, reset, cmd.mul_en, cnt_ff != INR_DEGREE_W'(0))

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the integer nth root block
// ----------------------------------------------------------------------------
// Drives requests of (value, degree) and compares every response root with
// a typed-in root or a floor-root predictor, which uses bitwise trial with
// an overflow-safe power check. A directed table covers zero, degree zero
// and one, full-scale values and exact powers. It is followed by random
// requests that focus on values near exact powers. Both handshakes are
// throttled at random in three phases: receiver slow, sender slow, neither.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = inr_pkg::INR_VALUE_W;
   localparam int DW = inr_pkg::INR_DEGREE_W;
   localparam int RANDOM_PER_PHASE = 226;
   // watchdog limit, far above any correct run
   localparam int unsigned CYCLE_LIMIT = 25_000_000;

   typedef struct packed {
      logic [VW-1:0] value;
      logic [DW-1:0] degree;
      logic          known;
      logic [VW-1:0] root;
   } root_case_type;

   typedef struct packed {
      logic [VW-1:0] value;
      logic [DW-1:0] degree;
      logic [VW-1:0] root;
   } root_expect_type;

   localparam logic [VW-1:0] ALL_ONES = {VW{1'b1}};
   localparam int N_DIRECTED = 24;

   // directed requests, root typed in where it is obvious
   localparam root_case_type DIRECTED_CASES [N_DIRECTED] = '{
      '{64'd0, 6'd2, 1'b1, 64'd0},
      '{64'd0, 6'd63, 1'b1, 64'd0},
      '{64'd0, 6'd0, 1'b1, 64'd0},
      '{ALL_ONES, 6'd1, 1'b1, ALL_ONES},
      '{ALL_ONES, 6'd0, 1'b1, ALL_ONES},
      '{64'h0123456789ABCDEF, 6'd1, 1'b1, 64'h0123456789ABCDEF},
      '{64'h0123456789ABCDEF, 6'd0, 1'b1, 64'h0123456789ABCDEF},
      '{64'd1, 6'd2, 1'b1, 64'd1},
      '{64'd1, 6'd63, 1'b1, 64'd1},
      '{ALL_ONES, 6'd2, 1'b1, 64'hFFFFFFFF},
      '{ALL_ONES, 6'd3, 1'b1, 64'd2642245},
      '{ALL_ONES, 6'd4, 1'b1, 64'd65535},
      '{ALL_ONES, 6'd63, 1'b1, 64'd2},
      '{64'h8000000000000000, 6'd63, 1'b1, 64'd2},
      '{64'h7FFFFFFFFFFFFFFF, 6'd63, 1'b1, 64'd1},
      '{64'hFFFFFFFE00000001, 6'd2, 1'b1, 64'hFFFFFFFF},
      '{64'hFFFFFFFE00000000, 6'd2, 1'b0, 64'd0},
      '{64'd1000000, 6'd2, 1'b1, 64'd1000},
      '{64'd999999, 6'd2, 1'b0, 64'd0},
      '{ALL_ONES, 6'd32, 1'b0, 64'd0},
      '{64'h5555555555555555, 6'd42, 1'b0, 64'd0},
      '{64'hAAAAAAAAAAAAAAAA, 6'd21, 1'b0, 64'd0},
      '{64'd2, 6'd63, 1'b1, 64'd1},
      '{64'd3, 6'd2, 1'b1, 64'd1}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [VW-1:0] req_value = '0;
   logic [DW-1:0] req_degree = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [VW-1:0] rsp_root;

   root_expect_type root_expect_q [$];
   root_expect_type oldest_root;
   int              send_idle_pct = 0;
   int              take_idle_pct = 0;
   int              error_count = 0;
   int              requests_sent = 0;
   int              roots_checked = 0;
   int              power_neighbors = 0;
   int unsigned     cycle_count = 0;

   integer_nth_root_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .req_degree (req_degree),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_root   (rsp_root)
   );

   always #2 clock = ~clock;

   // true when cand**deg does not exceed lim, without ever overflowing
   function automatic bit power_fits_under(logic [VW-1:0] cand, int deg,
                                           logic [VW-1:0] lim);
      logic [VW-1:0] acc;
      logic [VW-1:0] quot;
      acc  = VW'(1);
      quot = lim / cand;
      for (int i = 0; i < deg; i++) begin
         if (acc > quot) return 1'b0;
         acc = acc * cand;
      end
      return 1'b1;
   endfunction

   // floor of the degree-th root, degree zero and one pass the value
   function automatic logic [VW-1:0] floor_root(logic [VW-1:0] value,
                                                logic [DW-1:0] degree);
      logic [VW-1:0] root;
      logic [VW-1:0] cand;
      root = '0;
      if (degree <= 1) return value;
      for (int b = VW - 1; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (power_fits_under(cand, int'(degree), value)) root = cand;
      end
      return root;
   endfunction

   function automatic logic [VW-1:0] random_word();
      return {$urandom(), $urandom()};
   endfunction

   // random request, weighted toward exact powers and their neighbors
   task automatic pick_random_request(output logic [VW-1:0] value,
                                      output logic [DW-1:0] degree);
      int            kind;
      logic [VW-1:0] top;
      logic [VW-1:0] base;
      logic [VW-1:0] power;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         degree = ($urandom_range(0, 1) == 0) ? DW'($urandom_range(2, 6))
                                              : DW'($urandom_range(2, 63));
         top   = floor_root(ALL_ONES, degree);
         base  = VW'($urandom_range(1, int'(top[31:0])));
         power = VW'(1);
         for (int i = 0; i < int'(degree); i++) power = power * base;
         value = power + VW'($urandom_range(0, 2)) - 1;
         power_neighbors++;
      end else if (kind < 55) begin
         value  = random_word();
         degree = DW'($urandom_range(2, 8));
      end else if (kind < 75) begin
         value  = random_word() >> $urandom_range(0, VW - 1);
         degree = DW'($urandom_range(0, 63));
      end else if (kind < 90) begin
         value  = random_word();
         degree = DW'($urandom_range(0, 63));
      end else begin
         value  = VW'($urandom_range(0, 300));
         degree = DW'($urandom_range(0, 63));
      end
   endtask

   // present one request and hold it until taken, then queue its root
   task automatic send_request(logic [VW-1:0] value, logic [DW-1:0] degree,
                               logic known, logic [VW-1:0] known_root);
      bit              taken;
      root_expect_type entry;
      taken = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_value  <= value;
      req_degree <= degree;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      entry.value  = value;
      entry.degree = degree;
      entry.root   = known ? known_root : floor_root(value, degree);
      root_expect_q.push_back(entry);
      requests_sent++;
   endtask

   // receiver throttle
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   // response check, sampled mid-cycle ahead of the accepting edge
   always @(negedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (root_expect_q.size() == 0) begin
            $error("unexpected response: root %h with no request pending", rsp_root);
            error_count++;
         end else begin
            oldest_root = root_expect_q.pop_front();
            roots_checked++;
            if (rsp_root !== oldest_root.root) begin
               $error("root mismatch: expected %h actual %h (value %h degree %0d)",
                      oldest_root.root, rsp_root, oldest_root.value,
                      oldest_root.degree);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, root_expect_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      logic [VW-1:0] value;
      logic [DW-1:0] degree;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin
               send_idle_pct = 35;
               take_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               take_idle_pct = 35;
            end
            default: begin
               send_idle_pct = 0;
               take_idle_pct = 0;
            end
         endcase
         if (phase == 0) begin
            foreach (DIRECTED_CASES[i]) begin
               send_request(DIRECTED_CASES[i].value, DIRECTED_CASES[i].degree,
                            DIRECTED_CASES[i].known, DIRECTED_CASES[i].root);
            end
         end
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick_random_request(value, degree);
            send_request(value, degree, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      while (root_expect_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d requests (%0d directed, %0d near exact powers), %0d roots checked",
               requests_sent, N_DIRECTED, power_neighbors, roots_checked);
      $display("degrees 0..63 over full 64-bit values, three throttle phases, %0d cycles",
               cycle_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
